// File: rtl/core/dq_pkg.sv
package dq_pkg;

  localparam int unsigned WORD_W = 32;

  // operation codes carried in the request
  localparam logic [2:0] OP_PEEK       = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_REAR   = 3'd4;

  // status codes returned in the response
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [WORD_W-1:0] data_in;
  } dq_req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] front_word;
    logic signed [WORD_W-1:0] rear_word;
    logic                     is_empty;
    logic                     is_full;
    logic [1:0]               status;
  } dq_rsp_t;

endpackage

// File: rtl/core/dq_ram.sv
module dq_ram import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [WORD_W-1:0] rd_data_a,
  output logic [WORD_W-1:0] rd_data_b
);

  logic [WORD_W-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// File: rtl/core/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words.
// Request channel (req_valid/req_ready, payload req): an operation code
// (peek, push front, push rear, pop front, pop rear) and a word to push.
// Response channel (rsp_valid/rsp_ready, payload rsp): exactly one per
// request, giving the front and rear words after the operation (0 when
// empty), empty and full flags, and a status (ok, underflow, overflow).
// A pop on an empty queue or a push on a full one changes nothing.
// The accepting edge updates the pointers and writes the ring store; during
// state S_READ the store's registered read captures the front and rear
// entries; in state S_DATA the response register is loaded. One request
// is in flight at a time: the block takes no new request until the previous
// one's response has been loaded into the response register.
// A new request is taken while the previous response still waits; if the
// receiver stalls, the next response waits in its final cycle until the
// response register is free.
// Reset (rst, synchronous) empties the queue; store contents are not
// cleared, as only written entries are ever read.
module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  dq_req_t req,
  output logic    rsp_valid,
  input  logic    rsp_ready,
  output dq_rsp_t rsp
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DATA} state_t;

  state_t          state;
  logic [AW-1:0]   front_index;
  logic [CW-1:0]   occupancy;
  logic [1:0]      status;

  logic            accept;
  logic            rsp_load;
  logic            is_push;
  logic            is_pop;
  logic            empty;
  logic            full;
  logic [AW-1:0]   front_dec;
  logic [AW-1:0]   front_inc;
  logic [SW-1:0]   tail_sum;
  logic [SW-1:0]   tail_wrap;
  logic [SW-1:0]   rear_sum;
  logic [SW-1:0]   rear_wrap;
  logic [AW-1:0]   rear_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WORD_W-1:0] rd_front;
  logic [WORD_W-1:0] rd_rear;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign rsp_load  = (state == S_DATA) && (!rsp_valid || rsp_ready);

  // decode and ring arithmetic
  always_comb begin
    is_push   = (req.op == OP_PUSH_FRONT) || (req.op == OP_PUSH_REAR);
    is_pop    = (req.op == OP_POP_FRONT) || (req.op == OP_POP_REAR);
    empty     = (occupancy == '0);
    full      = (occupancy == CW'(DEPTH));
    front_dec = (front_index == '0) ? AW'(DEPTH - 1) : front_index - 1'b1;
    front_inc = (front_index == AW'(DEPTH - 1)) ? '0 : front_index + 1'b1;
    // slot just past the rear
    tail_sum  = SW'(front_index) + SW'(occupancy);
    tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    // slot holding the rear word
    rear_sum  = SW'(front_index) + SW'(occupancy) - SW'(1);
    rear_wrap = (rear_sum >= SW'(DEPTH)) ? rear_sum - SW'(DEPTH) : rear_sum;
    rear_addr = empty ? front_index : rear_wrap[AW-1:0];
    wr_en     = accept && is_push && !full;
    wr_addr   = (req.op == OP_PUSH_FRONT) ? front_dec : tail_wrap[AW-1:0];
  end

  dq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (req.data_in),
    .rd_addr_a (front_index),
    .rd_addr_b (rear_addr),
    .rd_data_a (rd_front),
    .rd_data_b (rd_rear)
  );

  // sequencer, pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      occupancy   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // a fresh load takes priority over the handshake that frees the register
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_push && full) begin
              status <= ST_OVER;
            end else if (is_pop && empty) begin
              status <= ST_UNDER;
            end else begin
              status <= ST_OK;
            end
            if (is_push && !full) begin
              occupancy <= occupancy + 1'b1;
              if (req.op == OP_PUSH_FRONT) begin
                front_index <= front_dec;
              end
            end else if (is_pop && !empty) begin
              occupancy <= occupancy - 1'b1;
              if (req.op == OP_POP_FRONT) begin
                front_index <= front_inc;
              end
            end
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DATA;
        end
        S_DATA: begin
          // wait for the response register to free up
          if (rsp_load) begin
            rsp.front_word <= empty ? '0 : rd_front;
            rsp.rear_word  <= empty ? '0 : rd_rear;
            rsp.is_empty   <= empty;
            rsp.is_full    <= full;
            rsp.status     <= status;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= CW'(DEPTH))
    else $error("occupancy beyond capacity");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("request not followed by read cycle");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |-> (rsp.front_word == '0 && rsp.rear_word == '0))
    else $error("empty response with non-zero words");

  a_under_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_UNDER) |-> rsp.is_empty)
    else $error("underflow while not empty");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_OVER) |-> rsp.is_full)
    else $error("overflow while not full");

endmodule

// File: verif/testbench.sv
module testbench;
  import dq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 700;

  // op codes the block treats as a peek
  localparam logic [2:0] OP_UNUSED_A = 3'd5;
  localparam logic [2:0] OP_UNUSED_B = 3'd6;
  localparam logic [2:0] OP_UNUSED_C = 3'd7;

  typedef enum int {FILL_BIAS, DRAIN_BIAS, EVEN_MIX} burst_mode_t;

  logic    clk;
  logic    rst;
  logic    req_valid;
  logic    req_ready;
  dq_req_t req;
  logic    rsp_valid;
  logic    rsp_ready;
  dq_rsp_t rsp;

  // Mirror of the ring store, plus the queue of front/rear views still owed
  class deque_tracker_t;
    logic signed [WORD_W-1:0] words[DEPTH];
    int unsigned head;
    int unsigned held;
    dq_rsp_t views[$];
    int failures;
    int checked;

    function new();
      head = 0;
      held = 0;
      failures = 0;
      checked = 0;
    endfunction

    function int pending();
      return views.size();
    endfunction

    // Apply one accepted request to the mirror and queue the view it yields
    function void note_request(dq_req_t r);
      dq_rsp_t v;
      v = '0;
      v.status = ST_OK;
      case (r.op)
        OP_PUSH_FRONT, OP_PUSH_REAR: begin
          if (held == DEPTH) begin
            v.status = ST_OVER;
          end else if (r.op == OP_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            words[head] = r.data_in;
            held++;
          end else begin
            words[(head + held) % DEPTH] = r.data_in;
            held++;
          end
        end
        OP_POP_FRONT, OP_POP_REAR: begin
          if (held == 0) begin
            v.status = ST_UNDER;
          end else begin
            if (r.op == OP_POP_FRONT) head = (head + 1) % DEPTH;
            held--;
          end
        end
        default: ;
      endcase
      // both views read as zero once the queue is empty
      if (held != 0) begin
        v.front_word = words[head];
        v.rear_word  = words[(head + held - 1) % DEPTH];
      end
      v.is_empty = (held == 0);
      v.is_full  = (held == DEPTH);
      views.push_back(v);
    endfunction

    function void check_response(dq_rsp_t got);
      dq_rsp_t want;
      if (views.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("response %0d arrived with nothing outstanding: %h", checked, got);
        checked++;
        return;
      end
      want = views.pop_front();
      if (got.front_word !== want.front_word || got.rear_word !== want.rear_word ||
          got.is_empty !== want.is_empty || got.is_full !== want.is_full ||
          got.status !== want.status) begin
        failures++;
        if (failures <= 10)
          $display({"response %0d (want/got): front %0d/%0d rear %0d/%0d ",
                    "empty %b/%b full %b/%b status %0d/%0d"}, checked,
                   want.front_word, got.front_word, want.rear_word, got.rear_word,
                   want.is_empty, got.is_empty, want.is_full, got.is_full,
                   want.status, got.status);
      end
      checked++;
    endfunction
  endclass

  deque_tracker_t tracker;
  bit quiet_sender;
  int cycles = 0;
  int rsp_seen = 0;

  double_ended_queue #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one request; called and returning at a falling edge
  task automatic drive_request(input logic [2:0] op, input logic signed [WORD_W-1:0] data);
    dq_req_t r;
    int gap;
    r.op = op;
    r.data_in = data;
    gap = quiet_sender ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  // Sender stops until every outstanding response is back
  task automatic drain_pause();
    req_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Response side: random stalls, quiet stretches and two long hold-offs
  initial begin
    int stall;
    rsp_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rsp_seen == 150 || rsp_seen == 520) stall = 90;
      else if ((rsp_seen / 60) % 3 == 1) stall = 0;
      else stall = $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      tracker.check_response(rsp);
      rsp_seen++;
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    logic signed [WORD_W-1:0] word;
    logic [2:0] op;
    burst_mode_t mode;
    int sent;
    int burst_len;
    int roll;
    bit paused;

    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    tracker = new();
    quiet_sender = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty queue: unused code, then both pops underflow
    drive_request(OP_UNUSED_C, 32'sd0);
    drive_request(OP_POP_FRONT, 32'sd0);
    drive_request(OP_POP_REAR, 32'sd0);
    // Fill from both ends, front push wrapping the index below zero
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       word = 32'sh7FFF_FFFF;
        1:       word = 32'sh8000_0000;
        2:       word = 32'sd0;
        3:       word = -32'sd1;
        default: word = $urandom;
      endcase
      drive_request(i[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, word);
    end
    // Full queue: both pushes overflow and the words are dropped, then peeks and a pop from each end
    drive_request(OP_PUSH_FRONT, 32'sh5A5A_5A5A);
    drive_request(OP_PUSH_REAR, -32'sh5A5A_5A5B);
    drive_request(OP_UNUSED_A, 32'sh1234_5678);
    drive_request(OP_UNUSED_B, 32'sh0);
    drive_request(OP_PEEK, 32'sh7FFF_FFFF);
    drive_request(OP_POP_FRONT, 32'sd0);
    drive_request(OP_POP_REAR, 32'sd0);
    drain_pause();

    // Random bursts biased to fill, drain or mix, so both ends get hit often
    sent = 0;
    paused = 1'b0;
    while (sent < RANDOM_REQS) begin
      mode = burst_mode_t'($urandom_range(0, 2));
      burst_len = $urandom_range(10, 40);
      quiet_sender = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst_len; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          FILL_BIAS:  roll = (roll < 75) ? 0 : (roll < 90) ? 1 : 2;
          DRAIN_BIAS: roll = (roll < 75) ? 1 : (roll < 90) ? 0 : 2;
          default:    roll = (roll < 45) ? 0 : (roll < 90) ? 1 : 2;
        endcase
        if (roll == 0)
          op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else if (roll == 1)
          op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
        else begin
          case ($urandom_range(0, 3))
            0:       op = OP_PEEK;
            1:       op = OP_UNUSED_A;
            2:       op = OP_UNUSED_B;
            default: op = OP_UNUSED_C;
          endcase
        end
        case ($urandom_range(0, 15))
          0:       word = 32'sh7FFF_FFFF;
          1:       word = 32'sh8000_0000;
          2:       word = 32'sd0;
          3:       word = -32'sd1;
          default: word = $urandom;
        endcase
        drive_request(op, word);
        sent++;
      end
      if (!paused && sent >= RANDOM_REQS / 2) begin
        drain_pause();
        paused = 1'b1;
      end
    end
    req_valid <= 1'b0;

    // Wait out the remaining responses, then a little longer for strays
    while (tracker.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/dq_pkg.sv
rtl/core/dq_ram.sv
rtl/core/double_ended_queue.sv
verif/testbench.sv
